// ===== rtl/edr_pkg.sv =====
// shared constants, types and the square root step for the distance unit
package edr_pkg;

  localparam int CoordBits = 16;

  // distance field and saturation limit
  localparam int DistW = 15;
  localparam logic [DistW-1:0] DistMax = '1;

  // once both magnitudes fit in DistW bits the radicand fits in RadW bits
  localparam int SqW   = 2 * DistW;
  localparam int RadW  = SqW + 1;
  localparam int WordW = RadW + 1;

  // digit by digit root: one step per radicand bit pair
  localparam int RootSteps     = WordW / 2;
  localparam int StepsPerStage = 2;
  localparam int RootStages    = RootSteps / StepsPerStage;
  localparam logic [WordW-1:0] TopBit = WordW'(1) << (WordW - 2);

  // abs, square, sum, root stages, round
  localparam int NumStages = 3 + RootStages + 1;

  typedef struct packed {
    logic [WordW-1:0] rem;
    logic [WordW-1:0] root;
  } root_t;

  function automatic root_t root_step(root_t s, logic [WordW-1:0] bitv);
    root_t            r;
    logic [WordW-1:0] trial;
    r     = s;
    trial = s.root + bitv;
    if (s.rem >= trial) begin
      r.rem  = s.rem - trial;
      r.root = s.root + (bitv << 1);
    end
    r.root = r.root >> 1;
    return r;
  endfunction

endpackage

// ===== rtl/euclidean_distance_rounded_unit.sv =====
// rounded euclidean distance between two points, pipelined integer square root
//
// Each transaction carries a target point and a position fix; the unit returns the
// distance between them rounded to nearest and saturated at 32767. A new transaction
// can be accepted every clock cycle while in_stall_o is low, and each result passes
// through the stages in order: one stage forms the absolute differences, one squares
// them, one adds the squares, eight stages each resolve two root bits, and the last
// stage rounds and saturates into the output register. Each
// stage holds its item until the next one is free, so in_stall_o only rises when
// every stage is full and the output is stalled. No state survives between items.
module euclidean_distance_rounded_unit #(
  parameter int COORD_BITS = edr_pkg::CoordBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [COORD_BITS-1:0]        target_x_i,
  input  logic [COORD_BITS-1:0]        target_y_i,
  input  logic [COORD_BITS-1:0]        here_x_i,
  input  logic [COORD_BITS-1:0]        here_y_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [edr_pkg::DistW-1:0]    distance_o
);

  localparam int DiffW = COORD_BITS + 1;
  localparam int ExtW  = (DiffW > edr_pkg::DistW) ? DiffW : edr_pkg::DistW + 1;
  localparam int NSt   = edr_pkg::NumStages;
  localparam int NRs   = edr_pkg::RootStages;

  // stage handshake
  logic [NSt-1:0] valid_q;
  logic [NSt-1:0] valid_d;
  logic [NSt-1:0] load;

  always_comb begin
    load[NSt-1] = !valid_q[NSt-1] || !out_stall_i;
    for (int k = NSt - 2; k >= 0; k--) begin
      load[k] = !valid_q[k] || load[k+1];
    end
    valid_d[0] = in_valid_i;
    for (int k = 1; k < NSt; k++) begin
      valid_d[k] = valid_q[k-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int k = 0; k < NSt; k++) begin
        if (load[k]) begin
          valid_q[k] <= valid_d[k];
        end
      end
    end
  end

  assign in_stall_o  = !load[0];
  assign out_valid_o = valid_q[NSt-1];

  // absolute differences
  logic signed [DiffW-1:0] dx, dy;
  logic        [DiffW-1:0] ax, ay;
  logic        [ExtW-1:0]  ax_ext, ay_ext;

  assign dx = $signed({target_x_i[COORD_BITS-1], target_x_i})
            - $signed({here_x_i[COORD_BITS-1], here_x_i});
  assign dy = $signed({target_y_i[COORD_BITS-1], target_y_i})
            - $signed({here_y_i[COORD_BITS-1], here_y_i});
  assign ax = dx[DiffW-1] ? DiffW'(-dx) : DiffW'(dx);
  assign ay = dy[DiffW-1] ? DiffW'(-dy) : DiffW'(dy);
  assign ax_ext = ExtW'(ax);
  assign ay_ext = ExtW'(ay);

  logic [edr_pkg::DistW-1:0] mag_x_q, mag_y_q;
  logic                      sat0_q;

  always_ff @(posedge clk_i) begin
    if (load[0]) begin
      mag_x_q <= ax_ext[edr_pkg::DistW-1:0];
      mag_y_q <= ay_ext[edr_pkg::DistW-1:0];
      // a difference beyond the limit already puts the distance beyond it
      sat0_q  <= (ax_ext > ExtW'(edr_pkg::DistMax)) || (ay_ext > ExtW'(edr_pkg::DistMax));
    end
  end

  // squares
  logic [edr_pkg::SqW-1:0] sq_x_q, sq_y_q;
  logic                    sat1_q;

  always_ff @(posedge clk_i) begin
    if (load[1]) begin
      sq_x_q <= edr_pkg::SqW'(mag_x_q) * edr_pkg::SqW'(mag_x_q);
      sq_y_q <= edr_pkg::SqW'(mag_y_q) * edr_pkg::SqW'(mag_y_q);
      sat1_q <= sat0_q;
    end
  end

  // sum
  logic [edr_pkg::RadW-1:0] rad_q;
  logic                     sat2_q;

  always_ff @(posedge clk_i) begin
    if (load[2]) begin
      rad_q  <= edr_pkg::RadW'(sq_x_q) + edr_pkg::RadW'(sq_y_q);
      sat2_q <= sat1_q;
    end
  end

  // root stages, two bits each
  edr_pkg::root_t rs_q [NRs];
  edr_pkg::root_t rs_d [NRs];
  logic           rsat_q [NRs];

  for (genvar i = 0; i < NRs; i++) begin : g_root
    edr_pkg::root_t rs_in;
    logic           sat_in;

    if (i == 0) begin : g_first
      assign rs_in.rem  = edr_pkg::WordW'(rad_q);
      assign rs_in.root = '0;
      assign sat_in     = sat2_q;
    end else begin : g_next
      assign rs_in  = rs_q[i-1];
      assign sat_in = rsat_q[i-1];
    end

    always_comb begin
      rs_d[i] = rs_in;
      for (int j = 0; j < edr_pkg::StepsPerStage; j++) begin
        rs_d[i] = edr_pkg::root_step(rs_d[i],
                    edr_pkg::TopBit >> (2 * (i * edr_pkg::StepsPerStage + j)));
      end
    end

    always_ff @(posedge clk_i) begin
      if (load[3+i]) begin
        rs_q[i]   <= rs_d[i];
        rsat_q[i] <= sat_in;
      end
    end
  end

  // round to nearest, then saturate
  logic [edr_pkg::WordW-1:0] rounded;
  logic [edr_pkg::DistW-1:0] distance_d, distance_q;

  always_comb begin
    rounded = rs_q[NRs-1].root;
    if (rs_q[NRs-1].rem > rs_q[NRs-1].root) begin
      rounded = rs_q[NRs-1].root + edr_pkg::WordW'(1);
    end
    if (rsat_q[NRs-1] || (rounded > edr_pkg::WordW'(edr_pkg::DistMax))) begin
      distance_d = edr_pkg::DistMax;
    end else begin
      distance_d = rounded[edr_pkg::DistW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (load[NSt-1]) begin
      distance_q <= distance_d;
    end
  end

  assign distance_o = distance_q;

endmodule

// ===== tb/euclidean_distance_rounded_unit_tb.sv =====
// testbench for the rounded euclidean distance unit with a self-checking distance predictor
`timescale 1ns / 100ps

module euclidean_distance_rounded_unit_tb;

  localparam int CW        = edr_pkg::CoordBits;
  localparam int DW        = edr_pkg::DistW;
  localparam int CoordMax  = (1 << (CW - 1)) - 1;
  localparam int CoordMin  = -(1 << (CW - 1));
  localparam int NumRandom = 700;
  localparam int MaxPrints = 100;

  typedef struct {
    logic [CW-1:0] tx;
    logic [CW-1:0] ty;
    logic [CW-1:0] hx;
    logic [CW-1:0] hy;
    logic [DW-1:0] distance;
  } query_t;

  typedef enum int {
    StallNone,
    StallLight,
    StallHeavy,
    StallPeriodic,
    StallLong
  } stall_mode_e;

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  logic [CW-1:0] target_x_i;
  logic [CW-1:0] target_y_i;
  logic [CW-1:0] here_x_i;
  logic [CW-1:0] here_y_i;
  logic          out_valid_o;
  logic          out_stall_i;
  logic [DW-1:0] distance_o;

  query_t pending_distance_q[$];
  query_t oldest_query;
  int     mismatch_count;
  int     burst_left;

  euclidean_distance_rounded_unit DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .target_x_i (target_x_i),
    .target_y_i (target_y_i),
    .here_x_i   (here_x_i),
    .here_y_i   (here_y_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .distance_o (distance_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // rounded, saturated distance: exact 32-bit arithmetic, root found one bit per step
  function automatic logic [DW-1:0] expected_distance(logic [CW-1:0] tx, logic [CW-1:0] ty,
                                                      logic [CW-1:0] hx, logic [CW-1:0] hy);
    logic signed [CW:0] dx;
    logic signed [CW:0] dy;
    logic [CW:0]        mag_x;
    logic [CW:0]        mag_y;
    logic [31:0]        rem;
    logic [31:0]        root;
    logic [31:0]        probe;
    dx    = $signed({tx[CW-1], tx}) - $signed({hx[CW-1], hx});
    dy    = $signed({ty[CW-1], ty}) - $signed({hy[CW-1], hy});
    mag_x = dx[CW] ? -dx : dx;
    mag_y = dy[CW] ? -dy : dy;
    // either side beyond the output range means the distance saturates
    if (mag_x > edr_pkg::DistMax || mag_y > edr_pkg::DistMax) begin
      return edr_pkg::DistMax;
    end
    rem  = mag_x * mag_x + mag_y * mag_y;
    root = '0;
    for (int i = 15; i >= 0; i--) begin
      probe = 32'd1 << (2 * i);
      if (rem >= root + probe) begin
        rem  = rem - (root + probe);
        root = root + (probe << 1);
      end
      root = root >> 1;
    end
    if (rem > root) begin
      root = root + 1;
    end
    if (root > edr_pkg::DistMax) begin
      root = edr_pkg::DistMax;
    end
    return root[DW-1:0];
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < MaxPrints) begin
      $display("%0t ns: mismatch: %s", $time, what);
    end
    mismatch_count++;
  endtask

  // one transaction; the sender then idles once its burst is used up
  task automatic send_point(input int tx, input int ty, input int hx, input int hy);
    query_t q;
    int     gap;
    @(negedge clk_i);
    in_valid_i = 1'b1;
    target_x_i = CW'(tx);
    target_y_i = CW'(ty);
    here_x_i   = CW'(hx);
    here_y_i   = CW'(hy);
    do @(posedge clk_i); while (in_stall_o);
    q.tx       = target_x_i;
    q.ty       = target_y_i;
    q.hx       = here_x_i;
    q.hy       = here_y_i;
    q.distance = expected_distance(q.tx, q.ty, q.hx, q.hy);
    pending_distance_q.push_back(q);
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 12);
      @(negedge clk_i);
      in_valid_i = 1'b0;
      target_x_i = CW'($urandom);
      target_y_i = CW'($urandom);
      here_x_i   = CW'($urandom);
      here_y_i   = CW'($urandom);
      repeat (gap - 1) @(negedge clk_i);
      // now and then a long stretch with no gaps at all
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(1, 30);
    end
  endtask

  // position that lies diff away from t and still fits the coordinate range
  function automatic int offset_coord(int t, int diff);
    int h;
    h = t - diff;
    if (h < CoordMin || h > CoordMax) begin
      h = t + diff;
    end
    return h;
  endfunction

  function automatic int random_coord();
    return int'($urandom_range(0, (1 << CW) - 1)) + CoordMin;
  endfunction

  task automatic test_coordinate_extremes();
    send_point(0, 0, 0, 0);
    send_point(CoordMin, CoordMin, CoordMin, CoordMin);
    send_point(CoordMax, CoordMin, CoordMax, CoordMin);
    send_point(CoordMax, CoordMax, CoordMin, CoordMin);
    send_point(CoordMin, 0, CoordMax, 0);
    send_point(0, CoordMin, 0, CoordMax);
    send_point(-1, 0, 0, 0);
    send_point(0, 0, 0, -1);
    send_point(CoordMax, 0, 0, 0);
    send_point(-CoordMax, 0, 0, 0);
  endtask

  task automatic test_large_difference();
    // exactly one past the output range on either axis
    send_point(0, 0, CoordMin, 0);
    send_point(0, CoordMin, 0, 0);
    send_point(CoordMax, 5, -1, 5);
  endtask

  task automatic test_rounding_and_saturation();
    send_point(3, 4, 0, 0);
    send_point(1, 1, 0, 0);
    send_point(4, 2, 0, 0);
    send_point(3, -2, 0, 0);
    send_point(2, 1, 0, 0);
    // root lands at the top of the output range or beyond it
    send_point(32766, 256, 0, 0);
    send_point(CoordMax, 181, 0, 0);
    send_point(CoordMax, 182, 0, 0);
    send_point(23170, 23170, 0, 0);
    send_point(-CoordMax, CoordMax, 0, 0);
  endtask

  task automatic test_random_points();
    int sel;
    int span;
    int tx;
    int ty;
    int dx;
    int dy;
    for (int n = 0; n < NumRandom; n++) begin
      sel = $urandom_range(0, 99);
      tx  = random_coord();
      ty  = random_coord();
      if (sel < 20) begin
        send_point(tx, ty, random_coord(), random_coord());
      end else begin
        if (sel < 80) begin
          span = $urandom_range(0, CW - 1);
          dx   = $urandom_range(0, (1 << span) - 1);
          span = $urandom_range(0, CW - 1);
          dy   = $urandom_range(0, (1 << span) - 1);
        end else if (sel < 90) begin
          dx = $urandom_range(23050, 23300);
          dy = $urandom_range(23050, 23300);
        end else begin
          dx = $urandom_range(32500, 32768);
          dy = $urandom_range(0, 400);
        end
        if ($urandom_range(0, 1)) dx = -dx;
        if ($urandom_range(0, 1)) dy = -dy;
        if ($urandom_range(0, 1)) begin
          send_point(tx, ty, offset_coord(tx, dx), offset_coord(ty, dy));
        end else begin
          send_point(tx, ty, offset_coord(tx, dy), offset_coord(ty, dx));
        end
      end
    end
  endtask

  // receiver back-pressure, switching between patterns every so often
  initial begin
    stall_mode_e mode;
    int          span;
    int          period;
    int          cyc;
    out_stall_i = 1'b0;
    cyc         = 0;
    forever begin
      mode   = stall_mode_e'($urandom_range(0, 4));
      span   = $urandom_range(16, 200);
      period = $urandom_range(2, 9);
      repeat (span) begin
        @(negedge clk_i);
        cyc++;
        case (mode)
          StallNone:     out_stall_i = 1'b0;
          StallLight:    out_stall_i = ($urandom_range(0, 3) == 0);
          StallHeavy:    out_stall_i = ($urandom_range(0, 3) != 0);
          StallPeriodic: out_stall_i = ((cyc % period) < (period / 2));
          default:       out_stall_i = ((cyc % 64) < 40);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_distance_q.size() == 0) begin
        report_mismatch($sformatf("distance %0d with no query outstanding", distance_o));
      end else begin
        oldest_query = pending_distance_q.pop_front();
        if (distance_o !== oldest_query.distance) begin
          report_mismatch($sformatf("target (%0d,%0d) here (%0d,%0d): distance %0d, expected %0d",
                                    $signed(oldest_query.tx), $signed(oldest_query.ty),
                                    $signed(oldest_query.hx), $signed(oldest_query.hy),
                                    distance_o, oldest_query.distance));
        end
      end
    end
  end

  initial begin
    mismatch_count = 0;
    burst_left     = $urandom_range(1, 30);
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    target_x_i     = '0;
    target_y_i     = '0;
    here_x_i       = '0;
    here_y_i       = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_coordinate_extremes();
    test_large_difference();
    test_rounding_and_saturation();
    test_random_points();

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_distance_q.size() != 0) @(posedge clk_i);
    repeat (edr_pkg::NumStages + 4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/edr_pkg.sv
rtl/euclidean_distance_rounded_unit.sv
tb/euclidean_distance_rounded_unit_tb.sv
